// ===== src/otsp_pkg.sv =====
// Shared types and constants for the OSC title sequence parser.
package otsp_pkg;

    localparam int PAYLOAD_DEPTH = 64;
    localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
    localparam int LEN_W         = ADDR_W + 1;

    localparam logic [LEN_W-1:0] FULL_LEN      = LEN_W'(PAYLOAD_DEPTH - 1);
    localparam logic [LEN_W-1:0] LAST_SLOT_LEN = LEN_W'(PAYLOAD_DEPTH - 2);

    localparam logic [7:0] BYTE_NUL    = 8'h00;
    localparam logic [7:0] BYTE_BEL    = 8'h07;
    localparam logic [7:0] BYTE_ESC    = 8'h1B;
    localparam logic [7:0] BYTE_ST8    = 8'h9C;
    localparam logic [7:0] BYTE_OSC8   = 8'h9D;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_9        = 8'h39;
    localparam logic [3:0] DIGIT_MAX_OK = 4'd2;

    typedef enum logic [1:0] {
        MODE_GROUND,
        MODE_ESC,
        MODE_OSC,
        MODE_OSC_ESC
    } t_mode;

    typedef enum logic [2:0] {
        S_RUN,
        S_WR2,
        S_NUM_RD,
        S_NUM_CHK,
        S_TTL_RD,
        S_TTL_CHK,
        S_TTL_END
    } t_state;

endpackage

// ===== src/otsp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module otsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/osc_title_sequence_parser.sv =====
// Top level of the OSC window title sequence parser.
//
// The slave stream takes one received terminal byte per request. The master
// stream gives the new window title one character per request, with tlast on
// the final character and tuser set on the single result of an empty title.
// The configuration write enables the 8-bit OSC and ST control bytes.
//
// An ordinary byte is taken directly in the run state. An ESC pair kept inside
// a payload is written as the ESC and then, in S_WR2, the byte after it, since
// the payload memory has one write port. When a sequence closes, the payload
// memory is walked from the start with one read port: each byte examined is
// read, then checked; the slave side is not ready during that walk.
// A stalled master side holds the walk, while a finished result waits in the
// output register and the next input byte is already taken.
// Reset returns the parser to ground with an empty payload and C1 controls
// off; the payload memory itself is not cleared.
module osc_title_sequence_parser
    import otsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] title_byte
    output logic       m_axis_tlast,
    output logic       m_axis_tuser    // [0] empty_title
);

    t_state           r_state, n_state;
    t_mode            r_mode, n_mode;
    logic             r_c1;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_pos, n_pos;
    logic [7:0]       r_pend, n_pend;
    logic [7:0]       r_hold, n_hold;
    logic             r_held, n_held;
    logic             r_num_nz, n_num_nz;
    logic             r_num_big, n_num_big;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_data, n_out_data;
    logic             r_out_last, n_out_last;
    logic             r_out_empty, n_out_empty;

    logic              w_accept;
    logic              w_slot_free;
    logic              w_last_slot;
    logic              w_close_byte;
    logic              w_is_digit;
    logic              w_pos_end;
    logic [7:0]        w_rdata;
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_waddr;
    logic [7:0]        w_ram_wdata;
    logic              w_ram_re;

    otsp_ram #(
        .WIDTH(8),
        .DEPTH(PAYLOAD_DEPTH)
    ) u_payload_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_ram_waddr),
        .i_wdata(w_ram_wdata),
        .i_re   (w_ram_re),
        .i_raddr(r_pos[ADDR_W-1:0]),
        .o_rdata(w_rdata)
    );

    assign s_axis_tready = (r_state == S_RUN);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign w_last_slot   = (r_len == LAST_SLOT_LEN);
    assign w_close_byte  = (s_axis_tdata == BYTE_BEL) || (r_c1 && (s_axis_tdata == BYTE_ST8));
    assign w_is_digit    = w_rdata inside {[CH_0:CH_9]};
    assign w_pos_end     = (r_pos >= r_len);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RUN: begin
                if (w_accept) begin
                    case (r_mode)
                        MODE_OSC: begin
                            if (s_axis_tdata != BYTE_ESC && (w_close_byte || w_last_slot)) begin
                                n_state = S_NUM_RD;
                            end
                        end
                        MODE_OSC_ESC: begin
                            if (s_axis_tdata == CH_BSLASH || w_last_slot) begin
                                n_state = S_NUM_RD;
                            end else begin
                                n_state = S_WR2;
                            end
                        end
                        default: n_state = S_RUN;
                    endcase
                end
            end
            S_WR2:     n_state = w_last_slot ? S_NUM_RD : S_RUN;
            S_NUM_RD:  n_state = w_pos_end ? S_RUN : S_NUM_CHK;
            S_NUM_CHK: begin
                if (w_is_digit) begin
                    n_state = S_NUM_RD;
                end else if (r_pos != '0 && w_rdata == CH_SEMI && !r_num_big) begin
                    n_state = S_TTL_RD;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_TTL_RD:  n_state = w_pos_end ? S_TTL_END : S_TTL_CHK;
            S_TTL_CHK: begin
                if (w_rdata == BYTE_NUL) begin
                    n_state = S_TTL_END;
                end else if (!r_held || w_slot_free) begin
                    n_state = S_TTL_RD;
                end
            end
            S_TTL_END: n_state = w_slot_free ? S_RUN : S_TTL_END;
            default:   n_state = S_RUN;
        endcase
    end

    always_comb begin
        n_mode      = r_mode;
        n_len       = r_len;
        n_pos       = r_pos;
        n_pend      = r_pend;
        n_hold      = r_hold;
        n_held      = r_held;
        n_num_nz    = r_num_nz;
        n_num_big   = r_num_big;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_empty = r_out_empty;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_len[ADDR_W-1:0];
        w_ram_wdata = s_axis_tdata;
        w_ram_re    = 1'b0;
        case (r_state)
            S_RUN: begin
                n_pos     = '0;
                n_held    = 1'b0;
                n_num_nz  = 1'b0;
                n_num_big = 1'b0;
                if (w_accept) begin
                    case (r_mode)
                        MODE_GROUND: begin
                            if (s_axis_tdata == BYTE_ESC) begin
                                n_mode = MODE_ESC;
                            end else if (r_c1 && s_axis_tdata == BYTE_OSC8) begin
                                n_mode = MODE_OSC;
                            end
                        end
                        MODE_ESC: begin
                            n_mode = (s_axis_tdata == CH_RBRACKET) ? MODE_OSC : MODE_GROUND;
                        end
                        MODE_OSC: begin
                            if (s_axis_tdata == BYTE_ESC) begin
                                n_mode = MODE_OSC_ESC;
                            end else if (w_close_byte) begin
                                n_mode = MODE_GROUND;
                            end else begin
                                w_ram_we = 1'b1;
                                n_len    = r_len + 1'b1;
                                if (w_last_slot) begin
                                    n_mode = MODE_GROUND;
                                end
                            end
                        end
                        default: begin
                            if (s_axis_tdata == CH_BSLASH) begin
                                n_mode = MODE_GROUND;
                            end else begin
                                w_ram_we    = 1'b1;
                                w_ram_wdata = BYTE_ESC;
                                n_len       = r_len + 1'b1;
                                n_pend      = s_axis_tdata;
                                if (w_last_slot) begin
                                    n_mode = MODE_GROUND;
                                end
                            end
                        end
                    endcase
                end
            end
            S_WR2: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = r_pend;
                n_len       = r_len + 1'b1;
                n_mode      = w_last_slot ? MODE_GROUND : MODE_OSC;
            end
            S_NUM_RD: begin
                if (w_pos_end) begin
                    n_len = '0;
                end else begin
                    w_ram_re = 1'b1;
                end
            end
            S_NUM_CHK: begin
                if (w_is_digit) begin
                    n_num_big = r_num_big || r_num_nz || (w_rdata[3:0] > DIGIT_MAX_OK);
                    n_num_nz  = r_num_nz || (w_rdata[3:0] != 4'd0);
                    n_pos     = r_pos + 1'b1;
                end else if (r_pos != '0 && w_rdata == CH_SEMI && !r_num_big) begin
                    n_pos = r_pos + 1'b1;
                end else begin
                    n_len = '0;
                end
            end
            S_TTL_RD: begin
                w_ram_re = !w_pos_end;
            end
            S_TTL_CHK: begin
                if (w_rdata != BYTE_NUL && (!r_held || w_slot_free)) begin
                    if (r_held) begin
                        n_out_valid = 1'b1;
                        n_out_data  = r_hold;
                        n_out_last  = 1'b0;
                        n_out_empty = 1'b0;
                    end
                    n_hold = w_rdata;
                    n_held = 1'b1;
                    n_pos  = r_pos + 1'b1;
                end
            end
            S_TTL_END: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_held ? r_hold : BYTE_NUL;
                    n_out_last  = 1'b1;
                    n_out_empty = !r_held;
                    n_len       = '0;
                end
            end
            default: begin
                n_len = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_mode      <= MODE_GROUND;
            r_c1        <= 1'b0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_c1 <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_pend      <= n_pend;
        r_hold      <= n_hold;
        r_held      <= n_held;
        r_num_nz    <= n_num_nz;
        r_num_big   <= n_num_big;
        r_out_data  <= n_out_data;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_empty;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= FULL_LEN)
        else $error("Payload length exceeds the store.");

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == BYTE_NUL))
        else $error("Empty title result is malformed.");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == S_RUN || r_state == S_WR2) && !w_ram_re)
        else $error("Payload write during the close walk.");

endmodule
